[design/tfd_pkg.sv]
// ----------------------------------------------------------------------------
// Tilt fall detector package
// Shared types, register indexes and reset values of the tilt fall detector.
// ----------------------------------------------------------------------------
package tfd_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 14;
   localparam int unsigned ANGLE_W     = 14;
   localparam int unsigned RUN_W       = 8;
   localparam int unsigned TILT_W      = 16;
   localparam int unsigned SUMSQ_W     = 32;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = 1;
   localparam int unsigned QUEUE_CNT_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROTECT_ENABLE       = 3'd0,
      CSR_FALLING_ANGLE        = 3'd1,
      CSR_FALL_SPEED           = 3'd2,
      CSR_FALLEN_ANGLE         = 3'd3,
      CSR_FALLING_FRAMES_LIMIT = 3'd4,
      CSR_FALLEN_FRAMES_LIMIT  = 3'd5
   } csr_index_type;

   localparam logic               RST_PROTECT_ENABLE       = 1'b1;
   localparam logic [ANGLE_W-1:0] RST_FALLING_ANGLE        = 14'd2574;
   localparam logic [ANGLE_W-1:0] RST_FALL_SPEED           = 14'd123;
   localparam logic [ANGLE_W-1:0] RST_FALLEN_ANGLE         = 14'd4289;
   localparam logic [RUN_W-1:0]   RST_FALLING_FRAMES_LIMIT = 8'd3;
   localparam logic [RUN_W-1:0]   RST_FALLEN_FRAMES_LIMIT  = 8'd2;

   localparam logic [SUMSQ_W-1:0] ROOT_FIRST_BIT = 32'h4000_0000;
   localparam logic [RUN_W-1:0]   RUN_MAX        = 8'hFF;

   typedef struct packed {
      logic               protect_enable;
      logic [ANGLE_W-1:0] falling_angle;
      logic [ANGLE_W-1:0] fall_speed;
      logic [ANGLE_W-1:0] fallen_angle;
      logic [RUN_W-1:0]   falling_frames_limit;
      logic [RUN_W-1:0]   fallen_frames_limit;
   } cfg_type;

   typedef struct packed {
      logic [SUMSQ_W-1:0] sum_sq;
      logic               beyond;
      logic               y_pos;
   } item_type;

endpackage

[design/tfd_front.sv]
// ----------------------------------------------------------------------------
// Tilt fall detector front end
// Accepts a tilt sample, classifies its axes and forms the sum of squares.
// ----------------------------------------------------------------------------
module tfd_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tfd_pkg::cfg_type                     cfg,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [tfd_pkg::TILT_W-1:0]    req_tilt_x,
   input  logic signed [tfd_pkg::TILT_W-1:0]    req_tilt_y,
   output logic                                 q_push,
   input  logic                                 q_full,
   output tfd_pkg::item_type                    q_wdata
);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_SQ_X = 4'b0010,
      F_SQ_Y = 4'b0100,
      F_SEND = 4'b1000
   } front_state_type;

   front_state_type                state_ff, state_in;
   logic [tfd_pkg::TILT_W-1:0]     ax_ff, ax_in;
   logic [tfd_pkg::TILT_W-1:0]     ay_ff, ay_in;
   logic [tfd_pkg::SUMSQ_W-1:0]    acc_ff, acc_in;
   logic                           beyond_ff, beyond_in;
   logic                           y_pos_ff, y_pos_in;
   logic [tfd_pkg::TILT_W-1:0]     abs_x;
   logic [tfd_pkg::TILT_W-1:0]     abs_y;
   logic [tfd_pkg::TILT_W-1:0]     mul_op;
   logic [tfd_pkg::SUMSQ_W-1:0]    square;

   assign abs_x  = req_tilt_x[tfd_pkg::TILT_W-1] ? tfd_pkg::TILT_W'(-req_tilt_x)
                                                 : tfd_pkg::TILT_W'(req_tilt_x);
   assign abs_y  = req_tilt_y[tfd_pkg::TILT_W-1] ? tfd_pkg::TILT_W'(-req_tilt_y)
                                                 : tfd_pkg::TILT_W'(req_tilt_y);
   assign mul_op = (state_ff == F_SQ_X) ? ax_ff : ay_ff;
   assign square = mul_op * mul_op;

   assign req_full = (state_ff != F_IDLE);
   assign q_push   = (state_ff == F_SEND) && !q_full;
   assign q_wdata  = '{sum_sq: acc_ff, beyond: beyond_ff, y_pos: y_pos_ff};

   always_comb begin
      state_in  = state_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      acc_in    = acc_ff;
      beyond_in = beyond_ff;
      y_pos_in  = y_pos_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_push) begin
               ax_in     = abs_x;
               ay_in     = abs_y;
               beyond_in = (abs_x > {2'b00, cfg.fallen_angle}) ||
                           (abs_y > {2'b00, cfg.fallen_angle});
               y_pos_in  = !req_tilt_y[tfd_pkg::TILT_W-1] && (req_tilt_y != '0);
               state_in  = F_SQ_X;
            end
         end
         F_SQ_X: begin
            acc_in   = square;
            state_in = F_SQ_Y;
         end
         F_SQ_Y: begin
            acc_in   = acc_ff + square;
            state_in = F_SEND;
         end
         F_SEND: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      acc_ff    <= acc_in;
      beyond_ff <= beyond_in;
      y_pos_ff  <= y_pos_in;
   end

endmodule

[design/tfd_queue.sv]
// ----------------------------------------------------------------------------
// Tilt fall detector item queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module tfd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tfd_pkg::item_type wdata,
   output logic              full,
   input  logic              pop,
   output tfd_pkg::item_type rdata,
   output logic              empty
);

   tfd_pkg::item_type                  entry_ff [tfd_pkg::QUEUE_DEPTH];
   logic [tfd_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tfd_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tfd_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                               do_push;
   logic                               do_pop;

   assign full    = (count_ff == tfd_pkg::QUEUE_CNT_W'(tfd_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + tfd_pkg::QUEUE_CNT_W'(do_push)
                               - tfd_pkg::QUEUE_CNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[design/tfd_back.sv]
// ----------------------------------------------------------------------------
// Tilt fall detector back end
// Takes the square root of each item and, while protection is enabled, updates the fall and fallen state.
// ----------------------------------------------------------------------------
module tfd_back (
   input  logic              clock,
   input  logic              reset,
   input  tfd_pkg::cfg_type  cfg,
   output logic              q_pop,
   input  logic              q_empty,
   input  tfd_pkg::item_type q_rdata,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_falling,
   output logic              rsp_fallen,
   output logic              rsp_on_front
);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_ROOT = 3'b010,
      B_DONE = 3'b100
   } back_state_type;

   back_state_type                  state_ff, state_in;
   logic [tfd_pkg::SUMSQ_W-1:0]     rem_ff, rem_in;
   logic [tfd_pkg::SUMSQ_W-1:0]     root_ff, root_in;
   logic [tfd_pkg::SUMSQ_W-1:0]     bit_ff, bit_in;
   logic                            beyond_ff, beyond_in;
   logic                            y_pos_ff, y_pos_in;
   logic [tfd_pkg::TILT_W-1:0]      last_mag_ff, last_mag_in;
   logic [tfd_pkg::RUN_W-1:0]       falling_run_ff, falling_run_in;
   logic [tfd_pkg::RUN_W-1:0]       steady_run_ff, steady_run_in;
   logic                            flag_ff, flag_in;
   logic [tfd_pkg::RUN_W-1:0]       fallen_run_ff, fallen_run_in;
   logic                            out_valid_ff, out_valid_in;
   logic                            out_falling_ff, out_falling_in;
   logic                            out_fallen_ff, out_fallen_in;
   logic                            out_on_front_ff, out_on_front_in;
   logic [tfd_pkg::SUMSQ_W-1:0]     trial;
   logic [tfd_pkg::TILT_W-1:0]      mag;
   logic signed [tfd_pkg::TILT_W:0] rise;
   logic                            frame_falling;
   logic                            out_free;
   logic                            finish;

   assign trial    = root_ff + bit_ff;
   assign mag      = root_ff[tfd_pkg::TILT_W-1:0];
   assign rise     = $signed({1'b0, mag}) - $signed({1'b0, last_mag_ff});
   assign frame_falling = (mag >= {2'b00, cfg.falling_angle}) ||
                          (rise > $signed({3'b000, cfg.fall_speed}));
   assign out_free = !out_valid_ff || rsp_pop;
   assign finish   = (state_ff == B_DONE) && out_free;
   assign q_pop    = (state_ff == B_IDLE) && !q_empty;

   assign rsp_empty    = !out_valid_ff;
   assign rsp_falling  = out_falling_ff;
   assign rsp_fallen   = out_fallen_ff;
   assign rsp_on_front = out_on_front_ff;

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      beyond_in = beyond_ff;
      y_pos_in  = y_pos_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               rem_in    = q_rdata.sum_sq;
               root_in   = '0;
               bit_in    = tfd_pkg::ROOT_FIRST_BIT;
               beyond_in = q_rdata.beyond;
               y_pos_in  = q_rdata.y_pos;
               state_in  = B_ROOT;
            end
         end
         B_ROOT: begin
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      last_mag_in    = last_mag_ff;
      falling_run_in = falling_run_ff;
      steady_run_in  = steady_run_ff;
      flag_in        = flag_ff;
      fallen_run_in  = fallen_run_ff;
      if (finish && cfg.protect_enable) begin
         if (frame_falling) begin
            falling_run_in = (falling_run_ff == tfd_pkg::RUN_MAX) ? falling_run_ff
                                                                  : falling_run_ff + 1'b1;
            steady_run_in  = '0;
         end else begin
            falling_run_in = '0;
            steady_run_in  = (steady_run_ff == tfd_pkg::RUN_MAX) ? steady_run_ff
                                                                 : steady_run_ff + 1'b1;
         end
         if (falling_run_in > cfg.falling_frames_limit) begin
            flag_in = 1'b1;
         end else if (steady_run_in > cfg.falling_frames_limit) begin
            flag_in = 1'b0;
         end
         last_mag_in = mag;
         if (beyond_ff) begin
            fallen_run_in = (fallen_run_ff == tfd_pkg::RUN_MAX) ? fallen_run_ff
                                                                : fallen_run_ff + 1'b1;
         end else begin
            fallen_run_in = '0;
         end
      end
   end

   always_comb begin
      out_valid_in    = out_valid_ff;
      out_falling_in  = out_falling_ff;
      out_fallen_in   = out_fallen_ff;
      out_on_front_in = out_on_front_ff;
      if (finish) begin
         out_valid_in    = 1'b1;
         out_falling_in  = cfg.protect_enable && flag_in;
         out_fallen_in   = (fallen_run_in > cfg.fallen_frames_limit);
         out_on_front_in = (fallen_run_in > cfg.fallen_frames_limit) && y_pos_ff;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= B_IDLE;
         last_mag_ff    <= '0;
         falling_run_ff <= '0;
         steady_run_ff  <= '0;
         flag_ff        <= 1'b0;
         fallen_run_ff  <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         last_mag_ff    <= last_mag_in;
         falling_run_ff <= falling_run_in;
         steady_run_ff  <= steady_run_in;
         flag_ff        <= flag_in;
         fallen_run_ff  <= fallen_run_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff          <= rem_in;
      root_ff         <= root_in;
      bit_ff          <= bit_in;
      beyond_ff       <= beyond_in;
      y_pos_ff        <= y_pos_in;
      out_falling_ff  <= out_falling_in;
      out_fallen_ff   <= out_fallen_in;
      out_on_front_ff <= out_on_front_in;
   end

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> out_valid_ff)
      else $error("result lost while waiting");

   a_take_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_IDLE && !q_empty) |=> (state_ff == B_ROOT))
      else $error("queued item not taken");

   a_runs_exclusive: assert property (@(posedge clock) disable iff (reset)
      !((falling_run_ff != '0) && (steady_run_ff != '0)))
      else $error("falling and steady runs both non-zero");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DONE) |-> (root_ff[tfd_pkg::SUMSQ_W-1:tfd_pkg::TILT_W] == '0))
      else $error("square root out of range");

endmodule

[design/tilt_fall_detector_top.sv]
// ----------------------------------------------------------------------------
// Tilt fall detector
// Flags falling and fallen states from per-frame X/Y tilt samples.
//
//   Channel   Ports                                 Beat taken when
//   req       req_push/full, req_tilt_x, tilt_y      push && !full
//   rsp       rsp_pop/empty, falling, fallen, front  pop && !empty
//   csr       csr_we, csr_index, csr_wdata           csr_we
//
// Front end steps: accept, two squares, hand over, one sample at a time.
// Back end: the 16-step square root loop, then the result is handed out;
// it takes the next item only once the last result is in the output register.
// Reset is synchronous; registers return to their defaults, state machines to idle.
// A waiting result stalls the back end first; the two-entry queue keeps the
// front end taking samples until the queue fills.
// ----------------------------------------------------------------------------
module tilt_fall_detector_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [tfd_pkg::TILT_W-1:0]    req_tilt_x,
   input  logic signed [tfd_pkg::TILT_W-1:0]    req_tilt_y,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic                                 rsp_falling,
   output logic                                 rsp_fallen,
   output logic                                 rsp_on_front,
   input  logic                                 csr_we,
   input  logic [tfd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [tfd_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   tfd_pkg::cfg_type  cfg_ff, cfg_in;
   tfd_pkg::item_type q_wdata;
   tfd_pkg::item_type q_rdata;
   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            tfd_pkg::CSR_PROTECT_ENABLE: begin
               cfg_in.protect_enable = csr_wdata[0];
            end
            tfd_pkg::CSR_FALLING_ANGLE: begin
               cfg_in.falling_angle = csr_wdata;
            end
            tfd_pkg::CSR_FALL_SPEED: begin
               cfg_in.fall_speed = csr_wdata;
            end
            tfd_pkg::CSR_FALLEN_ANGLE: begin
               cfg_in.fallen_angle = csr_wdata;
            end
            tfd_pkg::CSR_FALLING_FRAMES_LIMIT: begin
               cfg_in.falling_frames_limit = csr_wdata[tfd_pkg::RUN_W-1:0];
            end
            tfd_pkg::CSR_FALLEN_FRAMES_LIMIT: begin
               cfg_in.fallen_frames_limit = csr_wdata[tfd_pkg::RUN_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.protect_enable       <= tfd_pkg::RST_PROTECT_ENABLE;
         cfg_ff.falling_angle        <= tfd_pkg::RST_FALLING_ANGLE;
         cfg_ff.fall_speed           <= tfd_pkg::RST_FALL_SPEED;
         cfg_ff.fallen_angle         <= tfd_pkg::RST_FALLEN_ANGLE;
         cfg_ff.falling_frames_limit <= tfd_pkg::RST_FALLING_FRAMES_LIMIT;
         cfg_ff.fallen_frames_limit  <= tfd_pkg::RST_FALLEN_FRAMES_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_tilt_x (req_tilt_x),
      .req_tilt_y (req_tilt_y),
      .q_push     (q_push),
      .q_full     (q_full),
      .q_wdata    (q_wdata)
   );

   tfd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   tfd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_pop        (q_pop),
      .q_empty      (q_empty),
      .q_rdata      (q_rdata),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_falling  (rsp_falling),
      .rsp_fallen   (rsp_fallen),
      .rsp_on_front (rsp_on_front)
   );

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// Tilt fall detector testbench
// Drives tilt samples through the request queue under random idling and two
// long response hold-offs, predicts the falling, fallen and on_front flags of
// every sample, and checks each response beat in order. Registers are
// rewritten between phases while the block is idle, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 40;
   localparam int ANGLE_MAX      = 12868;

   typedef struct packed {
      logic falling;
      logic fallen;
      logic on_front;
   } flags_type;

   typedef enum {SEG_STEADY, SEG_FALL, SEG_NOISE, SEG_EXTREME} segment_type;

   class fall_scoreboard;
      tfd_pkg::cfg_type          cfg;
      logic [15:0]               last_mag;
      logic [tfd_pkg::RUN_W-1:0] falling_run;
      logic [tfd_pkg::RUN_W-1:0] steady_run;
      logic [tfd_pkg::RUN_W-1:0] fallen_run;
      logic                      falling_flag;
      flags_type                 flags_due[$];
      int                        errors;
      int                        beats;

      function new();
         cfg.protect_enable       = tfd_pkg::RST_PROTECT_ENABLE;
         cfg.falling_angle        = tfd_pkg::RST_FALLING_ANGLE;
         cfg.fall_speed           = tfd_pkg::RST_FALL_SPEED;
         cfg.fallen_angle         = tfd_pkg::RST_FALLEN_ANGLE;
         cfg.falling_frames_limit = tfd_pkg::RST_FALLING_FRAMES_LIMIT;
         cfg.fallen_frames_limit  = tfd_pkg::RST_FALLEN_FRAMES_LIMIT;
         last_mag     = '0;
         falling_run  = '0;
         steady_run   = '0;
         fallen_run   = '0;
         falling_flag = 1'b0;
         errors       = 0;
         beats        = 0;
      endfunction

      function void set_reg(tfd_pkg::csr_index_type idx,
                            logic [tfd_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            tfd_pkg::CSR_PROTECT_ENABLE:
               cfg.protect_enable = val[0];
            tfd_pkg::CSR_FALLING_ANGLE:
               cfg.falling_angle = val[tfd_pkg::ANGLE_W-1:0];
            tfd_pkg::CSR_FALL_SPEED:
               cfg.fall_speed = val[tfd_pkg::ANGLE_W-1:0];
            tfd_pkg::CSR_FALLEN_ANGLE:
               cfg.fallen_angle = val[tfd_pkg::ANGLE_W-1:0];
            tfd_pkg::CSR_FALLING_FRAMES_LIMIT:
               cfg.falling_frames_limit = val[tfd_pkg::RUN_W-1:0];
            tfd_pkg::CSR_FALLEN_FRAMES_LIMIT:
               cfg.fallen_frames_limit = val[tfd_pkg::RUN_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [15:0] tilt_root(int unsigned n);
         logic [15:0]     root;
         logic [15:0]     trial;
         longint unsigned sq;
         root = '0;
         for (int b = 15; b >= 0; b--) begin
            trial = root | (16'd1 << b);
            sq = longint'(trial) * trial;
            if (sq <= n) root = trial;
         end
         return root;
      endfunction

      function logic [tfd_pkg::RUN_W-1:0] bump(logic [tfd_pkg::RUN_W-1:0] run);
         return (run == tfd_pkg::RUN_MAX) ? tfd_pkg::RUN_MAX : run + 1'b1;
      endfunction

      function void note_sample(logic signed [15:0] x, logic signed [15:0] y);
         int          xi, yi, mag_i, last_i, rise, angle_i, speed_i;
         int unsigned ax, ay;
         logic [15:0] mag;
         logic        hot, is_fallen;
         flags_type   f;
         xi = x;
         yi = y;
         ax = (xi < 0) ? -xi : xi;
         ay = (yi < 0) ? -yi : yi;
         if (cfg.protect_enable) begin
            mag     = tilt_root(ax * ax + ay * ay);
            mag_i   = mag;
            last_i  = last_mag;
            angle_i = cfg.falling_angle;
            speed_i = cfg.fall_speed;
            rise    = mag_i - last_i;
            hot     = (mag_i >= angle_i) || (rise > speed_i);
            if (hot) begin
               falling_run = bump(falling_run);
               steady_run  = '0;
            end else begin
               falling_run = '0;
               steady_run  = bump(steady_run);
            end
            if (falling_run > cfg.falling_frames_limit) falling_flag = 1'b1;
            else if (steady_run > cfg.falling_frames_limit) falling_flag = 1'b0;
            last_mag = mag;
            if (ax > cfg.fallen_angle || ay > cfg.fallen_angle)
               fallen_run = bump(fallen_run);
            else
               fallen_run = '0;
         end
         is_fallen  = fallen_run > cfg.fallen_frames_limit;
         f.falling  = cfg.protect_enable && falling_flag;
         f.fallen   = is_fallen;
         f.on_front = is_fallen && (yi > 0);
         flags_due  = {flags_due, f};
      endfunction

      function void check_flags(logic falling, logic fallen, logic on_front);
         flags_type want;
         logic      bad;
         beats++;
         if (flags_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("beat %0d: unexpected result falling %b fallen %b on_front %b",
                        beats, falling, fallen, on_front);
            return;
         end
         want = flags_due.pop_front();
         bad = (falling !== want.falling) || (fallen !== want.fallen) ||
               (on_front !== want.on_front);
         if (bad) begin
            errors++;
            if (errors <= 10)
               $display("beat %0d: expected falling %b fallen %b on_front %b, got %b %b %b",
                        beats, want.falling, want.fallen, want.on_front,
                        falling, fallen, on_front);
         end
      endfunction

      function int pending();
         return flags_due.size();
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_push;
   logic                                req_full;
   logic signed [tfd_pkg::TILT_W-1:0]   req_tilt_x;
   logic signed [tfd_pkg::TILT_W-1:0]   req_tilt_y;
   logic                                rsp_empty;
   logic                                rsp_pop;
   logic                                rsp_falling;
   logic                                rsp_fallen;
   logic                                rsp_on_front;
   logic                                csr_we;
   logic [tfd_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [tfd_pkg::CSR_DATA_W-1:0]      csr_wdata;

   fall_scoreboard sb;
   int             tx_burst;
   int             rx_burst;
   int             rx_beats;
   int             idle_cycles = 0;
   segment_type    seg;
   int             seg_left;
   int             cur_x, cur_y, vel_x, vel_y, reach;

   int dir_tilt[25][2] = '{
      '{0, 0}, '{32767, 32767}, '{-32768, -32768}, '{-32768, 0}, '{0, 32767},
      '{0, -32768}, '{4289, 0}, '{4290, 0}, '{0, -4290}, '{-4290, 1},
      '{0, 0}, '{0, 0}, '{0, 0}, '{0, 0}, '{0, 0},
      '{123, 0}, '{247, 0}, '{2574, 0}, '{2574, 0}, '{2573, -1},
      '{-1, 1}, '{1, -1}, '{0, 4290}, '{4290, 4290}, '{-4290, 4290}
   };

   tfd_pkg::csr_index_type reg_order[6] = '{
      tfd_pkg::CSR_PROTECT_ENABLE, tfd_pkg::CSR_FALLING_ANGLE,
      tfd_pkg::CSR_FALL_SPEED, tfd_pkg::CSR_FALLEN_ANGLE,
      tfd_pkg::CSR_FALLING_FRAMES_LIMIT, tfd_pkg::CSR_FALLEN_FRAMES_LIMIT
   };

   tilt_fall_detector_top uut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_tilt_x   (req_tilt_x),
      .req_tilt_y   (req_tilt_y),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_falling  (rsp_falling),
      .rsp_fallen   (rsp_fallen),
      .rsp_on_front (rsp_on_front),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int pick_gap(inout int burst_left);
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(99);
      if (r < 4) begin
         burst_left = $urandom_range(60, 20);
         return 0;
      end
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic int clip(int v, int lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic logic [tfd_pkg::ANGLE_W-1:0] pick_angle();
      int r;
      r = $urandom_range(3);
      if (r == 0) return '0;
      if (r == 1) return tfd_pkg::ANGLE_W'(ANGLE_MAX);
      return tfd_pkg::ANGLE_W'($urandom_range(ANGLE_MAX));
   endfunction

   function automatic logic [tfd_pkg::RUN_W-1:0] pick_limit();
      int r;
      r = $urandom_range(4);
      if (r == 0) return '0;
      if (r == 1) return tfd_pkg::RUN_MAX;
      if (r == 2) return tfd_pkg::RUN_W'($urandom_range(255));
      return tfd_pkg::RUN_W'($urandom_range(6, 1));
   endfunction

   function automatic tfd_pkg::cfg_type random_config();
      tfd_pkg::cfg_type c;
      c.protect_enable       = ($urandom_range(4) != 0);
      c.falling_angle        = pick_angle();
      c.fall_speed           = pick_angle();
      c.fallen_angle         = pick_angle();
      c.falling_frames_limit = pick_limit();
      c.fallen_frames_limit  = pick_limit();
      return c;
   endfunction

   function automatic int extreme_value();
      case ($urandom_range(5))
         0: return -32768;
         1: return -32767;
         2: return -1;
         3: return 0;
         4: return 1;
         default: return 32767;
      endcase
   endfunction

   // well-formed motion most of the time: steady wobble, ramps into a fall
   task automatic next_tilt(output logic signed [15:0] x, output logic signed [15:0] y);
      int r;
      if (seg_left == 0) begin
         r = $urandom_range(99);
         if (r < 45) begin
            seg      = SEG_STEADY;
            seg_left = $urandom_range(40, 5);
            cur_x    = $urandom_range(4000) - 2000;
            cur_y    = $urandom_range(4000) - 2000;
         end else if (r < 75) begin
            seg      = SEG_FALL;
            seg_left = $urandom_range(40, 10);
            vel_x    = $urandom_range(900, 0);
            vel_y    = $urandom_range(900, 100);
            if ($urandom_range(1)) vel_x = -vel_x;
            if ($urandom_range(1)) vel_y = -vel_y;
            reach    = $urandom_range(32767, 3000);
         end else if (r < 90) begin
            seg      = SEG_NOISE;
            seg_left = $urandom_range(6, 1);
         end else begin
            seg      = SEG_EXTREME;
            seg_left = $urandom_range(4, 1);
         end
      end
      case (seg)
         SEG_STEADY: begin
            cur_x = clip(cur_x + $urandom_range(80) - 40, 32767);
            cur_y = clip(cur_y + $urandom_range(80) - 40, 32767);
         end
         SEG_FALL: begin
            cur_x = clip(cur_x + vel_x, reach);
            cur_y = clip(cur_y + vel_y, reach);
         end
         SEG_NOISE: begin
            cur_x = $urandom_range(65535) - 32768;
            cur_y = $urandom_range(65535) - 32768;
         end
         default: begin
            cur_x = extreme_value();
            cur_y = extreme_value();
         end
      endcase
      seg_left--;
      x = cur_x[15:0];
      y = cur_y[15:0];
   endtask

   task automatic send_beat(input logic signed [15:0] x, input logic signed [15:0] y);
      int gap;
      gap = pick_gap(tx_burst);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push   <= 1'b1;
      req_tilt_x <= x;
      req_tilt_y <= y;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_sample(x, y);
   endtask

   // drop push and wait for every outstanding response
   task automatic settle();
      req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_config(input tfd_pkg::cfg_type c);
      logic [tfd_pkg::CSR_DATA_W-1:0] val;
      foreach (reg_order[i]) begin
         case (reg_order[i])
            tfd_pkg::CSR_PROTECT_ENABLE:
               val = tfd_pkg::CSR_DATA_W'(c.protect_enable);
            tfd_pkg::CSR_FALLING_ANGLE:
               val = tfd_pkg::CSR_DATA_W'(c.falling_angle);
            tfd_pkg::CSR_FALL_SPEED:
               val = tfd_pkg::CSR_DATA_W'(c.fall_speed);
            tfd_pkg::CSR_FALLEN_ANGLE:
               val = tfd_pkg::CSR_DATA_W'(c.fallen_angle);
            tfd_pkg::CSR_FALLING_FRAMES_LIMIT:
               val = tfd_pkg::CSR_DATA_W'(c.falling_frames_limit);
            default:
               val = tfd_pkg::CSR_DATA_W'(c.fallen_frames_limit);
         endcase
         csr_we    <= 1'b1;
         csr_index <= reg_order[i];
         csr_wdata <= val;
         @(posedge clock);
         sb.set_reg(reg_order[i], val);
      end
      csr_we <= 1'b0;
   endtask

   task automatic run_frames(input int count);
      logic signed [15:0] x, y;
      repeat (count) begin
         next_tilt(x, y);
         send_beat(x, y);
      end
      settle();
   endtask

   initial begin
      tfd_pkg::cfg_type c;
      sb          = new();
      tx_burst    = 0;
      seg         = SEG_STEADY;
      seg_left    = 0;
      cur_x       = 0;
      cur_y       = 0;
      reset      <= 1'b1;
      req_push   <= 1'b0;
      req_tilt_x <= '0;
      req_tilt_y <= '0;
      csr_we     <= 1'b0;
      csr_index  <= tfd_pkg::CSR_PROTECT_ENABLE;
      csr_wdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tilt[i]) send_beat(dir_tilt[i][0][15:0], dir_tilt[i][1][15:0]);
      settle();

      // frozen state with protection off, under two fallen limits
      c = sb.cfg;
      c.protect_enable = 1'b0;
      write_config(c);
      run_frames(30);
      c.fallen_frames_limit = tfd_pkg::RUN_MAX;
      write_config(c);
      run_frames(30);

      // every frame hot: runs saturate
      c = '{1'b1, '0, '0, '0, tfd_pkg::RUN_MAX - 1'b1, tfd_pkg::RUN_MAX - 1'b1};
      write_config(c);
      run_frames(300);

      c = '{1'b1, tfd_pkg::ANGLE_W'(ANGLE_MAX), tfd_pkg::ANGLE_W'(ANGLE_MAX),
            tfd_pkg::ANGLE_W'(ANGLE_MAX), tfd_pkg::RUN_MAX, tfd_pkg::RUN_MAX};
      write_config(c);
      run_frames(100);

      c = '{1'b1, tfd_pkg::RST_FALLING_ANGLE, tfd_pkg::RST_FALL_SPEED,
            tfd_pkg::RST_FALLEN_ANGLE, '0, '0};
      write_config(c);
      run_frames(100);

      repeat (7) begin
         write_config(random_config());
         run_frames(155);
      end

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      int gap;
      rsp_pop  <= 1'b0;
      rx_burst = 0;
      rx_beats = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = pick_gap(rx_burst);
         // hold off long enough to fill the block
         if (rx_beats == 150 || rx_beats == 1000) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         sb.check_flags(rsp_falling, rsp_fallen, rsp_on_front);
         rx_beats++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
